>>> design/rcps_pkg.sv
package rcps_pkg;

	// Ring geometry and pulse limits.
	localparam int LIGHT_COUNT = 16;
	localparam int MAX_PULSES = 16;
	localparam int PULSE_CAP = (LIGHT_COUNT < MAX_PULSES) ? LIGHT_COUNT : MAX_PULSES;
	localparam int POS_W = $clog2(LIGHT_COUNT);
	localparam int LC_W = $clog2(LIGHT_COUNT + 1);
	localparam int CNT_W = $clog2(PULSE_CAP + 1);

	// Field and register widths.
	localparam int TIME_W = 16;
	localparam int IDX_W = 4;
	localparam int GAIN_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Fixed-point widths: ramp Q1.16, rate signed Q.16, unwrapped phase signed Q.16.
	localparam int RAMP_W = 17;
	localparam int RATE_W = 22;
	localparam int PHASE_W = 23;
	localparam int TGT_W = PHASE_W + LC_W - 16;
	localparam int DIFF_W = TGT_W + 1;

	localparam logic [RAMP_W-1:0] RAMP_ONE = 17'd65536;
	localparam logic [RAMP_W-1:0] RAMP_RESET = 17'd65536;
	localparam logic [15:0] RAMP_RATE_RESET = 16'd6554;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd6;
	localparam logic [3:0] OFFSET_RESET = 4'b1101;

	// Command queue between classifier and pulse emitter.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_OFFSET = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE,
		ST_STEP,
		ST_TGT,
		ST_CLS
	} front_state_t;

	// One burst of pulses: starting ring position, direction and pulse count.
	typedef struct packed {
		logic [POS_W-1:0] first;
		logic             back_dir;
		logic [CNT_W-1:0] count;
	} cmd_t;

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		if (p == POS_W'(LIGHT_COUNT - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		if (p == '0) begin
			r = POS_W'(LIGHT_COUNT - 1);
		end else begin
			r = p - 1'b1;
		end
		return r;
	endfunction

	// Ring position as reported on the output: the low four bits.
	function automatic logic [IDX_W-1:0] to_index(input logic [POS_W-1:0] p);
		logic [POS_W+IDX_W-1:0] w;
		w = {{IDX_W{1'b0}}, p};
		return w[IDX_W-1:0];
	endfunction

endpackage

>>> design/rcps_front.sv
module rcps_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [rcps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcps_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rcps_pkg::TIME_W-1:0]        elapsed_time,
	output logic                               q_push,
	output rcps_pkg::cmd_t                     q_cmd,
	input  logic                               q_full
);

	rcps_pkg::front_state_t state_q, state_d;

	// Configuration.
	logic [15:0] ramp_rate_q;
	logic [rcps_pkg::GAIN_W-1:0] speed_gain_q;
	logic [3:0] speed_offset_q;

	// Architectural state.
	logic [15:0] ring_phase_q;
	logic [rcps_pkg::RAMP_W-1:0] speed_ramp_q;
	logic [rcps_pkg::POS_W-1:0] active_pos_q;
	logic pos_valid_q;

	// Sequencer work registers.
	logic [rcps_pkg::TIME_W-1:0] elapsed_q;
	logic signed [rcps_pkg::RATE_W-1:0] rate_q;
	logic signed [rcps_pkg::RATE_W-1:0] step_q;
	logic signed [rcps_pkg::TGT_W-1:0] target_q;
	logic [rcps_pkg::POS_W-1:0] pos_new_q;
	logic [15:0] ring_new_q;

	logic in_accept;
	logic cls_done;
	logic cls_emit;

	// Rate and ramp update.
	logic [rcps_pkg::RAMP_W-1:0] folded;
	logic [rcps_pkg::RAMP_W+rcps_pkg::GAIN_W-1:0] fold_gain;
	logic signed [rcps_pkg::RATE_W-1:0] rate;
	logic [31:0] ramp_prod;
	logic [rcps_pkg::RAMP_W:0] ramp_sum;
	logic [rcps_pkg::RAMP_W-1:0] ramp_next;

	// Phase step and target.
	logic signed [38:0] step_prod;
	logic signed [rcps_pkg::PHASE_W-1:0] phase;
	logic signed [rcps_pkg::PHASE_W+rcps_pkg::LC_W:0] phase_l;
	logic [15+rcps_pkg::LC_W:0] ring_l;

	// Classification.
	logic signed [rcps_pkg::TGT_W-1:0] cur;
	logic signed [rcps_pkg::DIFF_W-1:0] diff;
	logic signed [rcps_pkg::DIFF_W:0] adj;
	logic [rcps_pkg::DIFF_W-1:0] span;
	logic [rcps_pkg::DIFF_W:0] adj_abs;
	logic [rcps_pkg::DIFF_W+1:0] count_raw;
	logic [rcps_pkg::DIFF_W+1:0] count_cap;
	logic span_big;
	logic dir_back;
	logic [rcps_pkg::POS_W-1:0] cur_mod;
	logic [rcps_pkg::POS_W-1:0] base_pos;

	assign in_accept = in_valid && !in_stall;

	assign folded = (speed_ramp_q > rcps_pkg::RAMP_ONE)
		? ((rcps_pkg::RAMP_ONE << 1) - speed_ramp_q) : speed_ramp_q;
	assign fold_gain = folded * speed_gain_q;
	assign rate = $signed({1'b0, fold_gain})
		+ $signed({{(rcps_pkg::RATE_W - 20){speed_offset_q[3]}}, speed_offset_q, 16'b0});
	assign ramp_prod = ramp_rate_q * elapsed_q;
	assign ramp_sum = {1'b0, speed_ramp_q} + {2'b0, ramp_prod[31:16]};
	assign ramp_next = ramp_sum[rcps_pkg::RAMP_W] ? '0 : ramp_sum[rcps_pkg::RAMP_W-1:0];

	assign step_prod = $signed({1'b0, elapsed_q}) * rate_q;

	assign phase = $signed({7'b0, ring_phase_q})
		+ $signed({step_q[rcps_pkg::RATE_W-1], step_q});
	assign phase_l = phase * $signed({1'b0, rcps_pkg::LC_W'(rcps_pkg::LIGHT_COUNT)});
	assign ring_l = phase[15:0] * rcps_pkg::LC_W'(rcps_pkg::LIGHT_COUNT);

	always_comb begin
		cur = pos_valid_q
			? $signed({{(rcps_pkg::TGT_W - rcps_pkg::POS_W){1'b0}}, active_pos_q}) : '1;
		cur_mod = pos_valid_q ? active_pos_q : rcps_pkg::POS_W'(rcps_pkg::LIGHT_COUNT - 1);
		dir_back = rate_q[rcps_pkg::RATE_W-1];
		diff = $signed({target_q[rcps_pkg::TGT_W-1], target_q})
			- $signed({cur[rcps_pkg::TGT_W-1], cur});
		span = diff[rcps_pkg::DIFF_W-1] ? rcps_pkg::DIFF_W'(-diff) : rcps_pkg::DIFF_W'(diff);
		adj = dir_back ? ($signed({diff[rcps_pkg::DIFF_W-1], diff}) + $signed(2'sb01))
			: ($signed({diff[rcps_pkg::DIFF_W-1], diff}) - $signed(2'sb01));
		adj_abs = adj[rcps_pkg::DIFF_W] ? (rcps_pkg::DIFF_W + 1)'(-adj)
			: (rcps_pkg::DIFF_W + 1)'(adj);
		span_big = span > rcps_pkg::DIFF_W'(rcps_pkg::LIGHT_COUNT);
		// A jump beyond a whole ring ends at the target after one full lap.
		if (span_big) begin
			count_raw = (rcps_pkg::DIFF_W + 2)'(rcps_pkg::LIGHT_COUNT);
			base_pos = pos_new_q;
		end else begin
			count_raw = {1'b0, adj_abs} + 1'b1;
			base_pos = cur_mod;
		end
		count_cap = (count_raw > (rcps_pkg::DIFF_W + 2)'(rcps_pkg::PULSE_CAP))
			? (rcps_pkg::DIFF_W + 2)'(rcps_pkg::PULSE_CAP) : count_raw;
		q_cmd.first = dir_back ? rcps_pkg::pos_dec(base_pos) : rcps_pkg::pos_inc(base_pos);
		q_cmd.back_dir = dir_back;
		q_cmd.count = count_cap[rcps_pkg::CNT_W-1:0];
	end

	assign cls_emit = (diff != '0);
	assign cls_done = (state_q == rcps_pkg::ST_CLS) && (!cls_emit || !q_full);
	assign q_push = cls_done && cls_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		case (state_q)
			rcps_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = rcps_pkg::ST_RATE;
				end
			end
			rcps_pkg::ST_RATE: state_d = rcps_pkg::ST_STEP;
			rcps_pkg::ST_STEP: state_d = rcps_pkg::ST_TGT;
			rcps_pkg::ST_TGT:  state_d = rcps_pkg::ST_CLS;
			rcps_pkg::ST_CLS: begin
				if (cls_done) begin
					state_d = rcps_pkg::ST_IDLE;
				end
			end
			default: state_d = rcps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_rate_q <= rcps_pkg::RAMP_RATE_RESET;
			speed_gain_q <= rcps_pkg::GAIN_RESET;
			speed_offset_q <= rcps_pkg::OFFSET_RESET;
			ring_phase_q <= '0;
			speed_ramp_q <= rcps_pkg::RAMP_RESET;
			active_pos_q <= '0;
			pos_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					rcps_pkg::CFG_RAMP_RATE:    ramp_rate_q <= cfg_data;
					rcps_pkg::CFG_SPEED_GAIN:   speed_gain_q <= cfg_data[rcps_pkg::GAIN_W-1:0];
					rcps_pkg::CFG_SPEED_OFFSET: speed_offset_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			// The rate is taken from the ramp before it grows.
			if (state_q == rcps_pkg::ST_RATE) begin
				speed_ramp_q <= ramp_next;
			end
			if (cls_done) begin
				ring_phase_q <= ring_new_q;
				if (cls_emit) begin
					active_pos_q <= pos_new_q;
					pos_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			elapsed_q <= elapsed_time;
		end
		if (state_q == rcps_pkg::ST_RATE) begin
			rate_q <= rate;
		end
		if (state_q == rcps_pkg::ST_STEP) begin
			step_q <= step_prod[37:16];
		end
		if (state_q == rcps_pkg::ST_TGT) begin
			target_q <= phase_l[rcps_pkg::PHASE_W+rcps_pkg::LC_W-1:16];
			ring_new_q <= phase[15:0];
			pos_new_q <= ring_l[15+rcps_pkg::POS_W:16];
		end
	end

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_cmd.count != '0)
			&& (q_cmd.count <= rcps_pkg::CNT_W'(rcps_pkg::PULSE_CAP)))
		else $error("pushed command has a bad pulse count");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == rcps_pkg::ST_RATE))
		else $error("accepted transaction did not start the sequence");

	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(pos_valid_q))
		else $error("position valid dropped");

endmodule

>>> design/rcps_queue.sv
module rcps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rcps_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output rcps_pkg::cmd_t pop_cmd,
	output logic           empty
);

	rcps_pkg::cmd_t entry_q [rcps_pkg::QUEUE_DEPTH];
	logic [rcps_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rcps_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rcps_pkg::QCNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == rcps_pkg::QCNT_W'(rcps_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rcps_pkg::QPTR_W'(rcps_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rcps_pkg::QPTR_W'(rcps_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> design/rcps_back.sv
module rcps_back (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         q_pop,
	input  rcps_pkg::cmd_t               q_cmd,
	input  logic                         q_empty,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rcps_pkg::IDX_W-1:0]   light_index,
	output logic                         last_pulse
);

	logic busy_q;
	logic [rcps_pkg::CNT_W-1:0] rem_q;
	logic [rcps_pkg::POS_W-1:0] pos_q;
	logic back_dir_q;
	logic out_valid_q;
	logic [rcps_pkg::IDX_W-1:0] index_q;
	logic last_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop = !busy_q && !q_empty;

	assign out_valid = out_valid_q;
	assign light_index = index_q;
	assign last_pulse = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				rem_q <= q_cmd.count;
			end else if (out_free && busy_q) begin
				rem_q <= rem_q - 1'b1;
				busy_q <= (rem_q != rcps_pkg::CNT_W'(1));
			end
			if (out_free) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pos_q <= q_cmd.first;
			back_dir_q <= q_cmd.back_dir;
		end else if (out_free && busy_q) begin
			pos_q <= back_dir_q ? rcps_pkg::pos_dec(pos_q) : rcps_pkg::pos_inc(pos_q);
		end
		if (out_free && busy_q) begin
			index_q <= rcps_pkg::to_index(pos_q);
			last_q <= (rem_q == rcps_pkg::CNT_W'(1));
		end
	end

	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0))
		else $error("emitter busy with no pulses left");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !busy_q)
		else $error("command taken while a burst is running");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_free && (rem_q == rcps_pkg::CNT_W'(1)))
			|=> (out_valid_q && last_q && !busy_q))
		else $error("final pulse of a burst not flagged");

endmodule

>>> design/ring_chase_pulse_sequencer_top.sv
// Ring chase pulse sequencer. Each input transaction carries the time since the previous
// tick (Q0.16 seconds). The block folds its speed ramp into a triangle, applies the gain
// and offset to get a signed rotation rate, advances the ring phase, and emits one output
// transaction per light position crossed, in the direction of the rate, with last_pulse
// set on the final one of the tick; a tick that crosses no position produces nothing.
// The front sequencer works through accept, rate, phase step, target and classify states
// for each tick, a chain of registered multiplies. The emitter behind a two-entry
// command queue sends one pulse per cycle while the output is not stalled, after a
// separate load step for each burst; a burst holds up to sixteen pulses, a full ring.
// Configuration writes are accepted in any cycle (cfg_ready is always high) but must
// only be issued while the block is idle; index 3 is ignored.
module ring_chase_pulse_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcps_pkg::CFG_DATA_W-1:0]   cfg_data,

	// Tick input.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rcps_pkg::TIME_W-1:0]       elapsed_time,

	// Pulse output.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rcps_pkg::IDX_W-1:0]        light_index,
	output logic                              last_pulse
);

	// Commands between the classifier and the emitter.
	rcps_pkg::cmd_t push_cmd;
	rcps_pkg::cmd_t pop_cmd;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	// Register writes never wait.
	assign cfg_ready = 1'b1;

	// The front computes the rate and target and turns each tick into at most one burst
	// command. It holds in its classify state while the queue is full and it has a command to push.
	rcps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.elapsed_time (elapsed_time),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.q_full       (q_full)
	);

	// The queue lets the next tick be worked out while a burst is still being sent.
	rcps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// The back walks the ring from the first position, one output transaction per step,
	// through a registered output stage that holds under stall.
	rcps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_pop       (q_pop),
		.q_cmd       (pop_cmd),
		.q_empty     (q_empty),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.light_index (light_index),
		.last_pulse  (last_pulse)
	);

endmodule

>>> verif/tb_ring_chase_pulse_sequencer_top.sv
module tb_ring_chase_pulse_sequencer_top;
	import rcps_pkg::*;

	// The ring chase sequencer is checked against a cycle-free predictor that
	// runs once per accepted tick. It holds its own copy of the ring phase, the
	// speed ramp, the last reached position and the three control registers.
	// Every pulse the predictor produces goes into a queue, and the monitor
	// compares each pulse transaction leaving the block with the oldest entry.

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int FINAL_WAIT = 20000;

	// Index 3 decodes to no register; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_SENDER,
		PACE_RECEIVER,
		PACE_BOTH
	} pace_t;

	typedef struct {
		logic [IDX_W-1:0] light;
		logic             last;
	} pulse_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [TIME_W-1:0] elapsed_time = '0;

	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [IDX_W-1:0] light_index;
	logic             last_pulse;

	ring_chase_pulse_sequencer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.light_index  (light_index),
		.last_pulse   (last_pulse)
	);

	// Ticks waiting to be offered and pulses the block still owes us.
	logic [TIME_W-1:0] tick_q[$];
	pulse_t            due_pulses[$];

	pace_t       pace = PACE_FREE;
	logic        hold_armed = 1'b0;
	int          hold_count = 0;
	int          errors = 0;
	int unsigned cycle_count = 0;

	// Predictor copy of the control registers, tracking every accepted write.
	logic [15:0] m_ramp_rate;
	int          m_gain;
	int          m_offset;

	// Predictor copy of the block state.
	logic [15:0] m_phase;
	logic [16:0] m_ramp;
	int          m_position;
	logic        m_pos_valid;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Reduce a signed position onto the ring, always landing in [0, LIGHT_COUNT).
	function automatic longint ring_wrap(input longint x);
		longint r;
		r = x % LIGHT_COUNT;
		if (r < 0) begin
			r = r + LIGHT_COUNT;
		end
		return r;
	endfunction

	// Advance the ring by one tick and queue every pulse it causes.
	task automatic advance_ring(input logic [TIME_W-1:0] et);
		longint folded, rate, phase, target, cur, first, dir, span, count, i;
		pulse_t p;
		// The rate uses the ramp value from before this tick's growth.
		folded = (m_ramp > 17'd65536) ? 131072 - longint'(m_ramp) : longint'(m_ramp);
		rate = folded * m_gain + longint'(m_offset) * 65536;
		if (longint'(m_ramp) + ((longint'(m_ramp_rate) * longint'(et)) >> 16) >= 131072) begin
			m_ramp = '0;
		end else begin
			m_ramp = m_ramp + 17'((longint'(m_ramp_rate) * longint'(et)) >> 16);
		end
		// Arithmetic right shift of a signed value gives the floor, which is what
		// both the phase step and the target position need for backward motion.
		phase = longint'(m_phase) + ((longint'(et) * rate) >>> 16);
		target = (phase * LIGHT_COUNT) >>> 16;
		cur = m_pos_valid ? longint'(m_position) : -1;
		if (target != cur) begin
			dir = (rate >= 0) ? 1 : -1;
			span = (target > cur) ? target - cur : cur - target;
			if (span > LIGHT_COUNT) begin
				first = target - dir * (LIGHT_COUNT - 1);
			end else begin
				first = cur + dir;
			end
			count = ((target > first) ? target - first : first - target) + 1;
			if (count > PULSE_CAP) begin
				count = PULSE_CAP;
			end
			for (i = 0; i < count; i++) begin
				p.light = IDX_W'(ring_wrap(first + dir * i));
				p.last = (i == count - 1);
				due_pulses.push_back(p);
			end
			m_position = int'(ring_wrap(target));
			m_pos_valid = 1'b1;
		end
		m_phase = phase[15:0];
	endtask

	// Tick driver. A stalled transaction is held unchanged; otherwise the next
	// tick is offered unless the current pacing makes the sender sit out.
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid) begin
				advance_ring(elapsed_time);
			end
			if (tick_q.size() > 0 &&
				!((pace == PACE_SENDER && $urandom_range(99) < 73) ||
				  (pace == PACE_BOTH && $urandom_range(99) < 13))) begin
				in_valid <= 1'b1;
				elapsed_time <= tick_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall. A long hold-off, once armed, keeps the output stalled
	// so the command queue fills and the block has to stall its tick input.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_armed && hold_count < HOLD_LEN) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else if (pace == PACE_RECEIVER) begin
			out_stall <= ($urandom_range(99) < 73);
		end else if (pace == PACE_BOTH) begin
			out_stall <= ($urandom_range(99) < 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Pulse monitor: every accepted output transaction must match the oldest
	// predicted pulse, field by field.
	always @(posedge clk) begin : pulse_monitor
		pulse_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_pulses.size() == 0) begin
				$display("%0t: unexpected pulse light_index=%0d last_pulse=%0d",
					$time, light_index, last_pulse);
				errors++;
			end else begin
				want = due_pulses.pop_front();
				if (light_index !== want.light) begin
					$display("%0t: light_index expected %0d got %0d",
						$time, want.light, light_index);
					errors++;
				end
				if (last_pulse !== want.last) begin
					$display("%0t: last_pulse expected %0d got %0d",
						$time, want.last, last_pulse);
					errors++;
				end
			end
		end
	end

	// Write one register. Called at a rising edge; the valid is left high so the
	// caller can chain writes without a gap and must lower it after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RAMP_RATE: begin
				m_ramp_rate = data;
			end
			CFG_SPEED_GAIN: begin
				m_gain = int'(data[3:0]);
			end
			CFG_SPEED_OFFSET: begin
				m_offset = int'($signed(data[3:0]));
			end
			default: begin
			end
		endcase
	endtask

	// Program all three registers. Junk goes into the unused upper data bits
	// of the narrow registers so that every data bit is exercised.
	task automatic program_regs(input logic [15:0] rr, input logic [3:0] gain,
		input logic [3:0] offset);
		@(posedge clk);
		write_reg(CFG_RAMP_RATE, rr);
		write_reg(CFG_SPEED_GAIN, {12'($urandom), gain});
		write_reg(CFG_SPEED_OFFSET, {12'($urandom), offset});
		cfg_valid <= 1'b0;
	endtask

	// Wait until every tick is accepted and every pulse has arrived, then let
	// extra cycles pass for a tick that produced no pulse and may still be in
	// the front sequencer.
	task automatic settle(input int extra);
		do @(negedge clk); while (tick_q.size() != 0 || in_valid || due_pulses.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	// Random ticks: half of them short frames that move a few positions, with
	// long ones that can jump the whole ring and a share of idle-length frames.
	task automatic queue_random(input int n);
		int k;
		int pick;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				tick_q.push_back(TIME_W'($urandom_range(4095)));
			end else if (pick < 50) begin
				tick_q.push_back(TIME_W'($urandom_range(511)));
			end else if (pick < 85) begin
				tick_q.push_back(TIME_W'($urandom));
			end else if (pick < 92) begin
				tick_q.push_back(TIME_W'($urandom_range(65535, 61440)));
			end else begin
				tick_q.push_back(TIME_W'($urandom_range(3)));
			end
		end
	endtask

	task automatic random_config();
		logic [15:0] rr;
		case ($urandom_range(3))
			0: rr = 16'd0;
			1: rr = 16'hFFFF;
			default: rr = 16'($urandom);
		endcase
		program_regs(rr, 4'($urandom), 4'($urandom));
	endtask

	initial begin : stimulus
		int p;
		int k;
		int waited;

		m_ramp_rate = RAMP_RATE_RESET;
		m_gain = int'(GAIN_RESET);
		m_offset = int'($signed(OFFSET_RESET));
		m_phase = '0;
		m_ramp = RAMP_RESET;
		m_position = 0;
		m_pos_valid = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset registers: the first tick moves from the
		// "no position yet" state onto position zero, an idle-length frame right
		// after it crosses nothing, and the long frames jump more than a ring.
		tick_q = '{16'd0, 16'd0, 16'd1, 16'd4096, 16'd2731, 16'hFFFF,
			16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
		settle(SETTLE_CYCLES);

		// Largest gain, ramp rate and offset: the ramp passes 2.0 and drops to
		// zero, and the fast rate keeps jumping past a full ring.
		program_regs(16'hFFFF, 4'd15, 4'd7);
		tick_q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1};
		settle(SETTLE_CYCLES);

		// Zero gain with the most negative offset: backward motion, wrapping
		// below position zero.
		program_regs(16'd0, 4'd0, 4'b1000);
		tick_q = '{16'd300, 16'd4096, 16'hFFFF, 16'd1};
		settle(SETTLE_CYCLES);

		// A write to the unused index must change nothing; then a zero rate,
		// which counts as forward motion but never moves the ring.
		@(posedge clk);
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		tick_q = '{16'd2048};
		settle(SETTLE_CYCLES);
		program_regs(16'd0, 4'd0, 4'd0);
		tick_q = '{16'hFFFF, 16'd0};
		settle(SETTLE_CYCLES);

		// Random part, two register settings under each pacing.
		for (p = 0; p < 8; p++) begin
			pace = pace_t'(p % 4);
			random_config();
			queue_random(35);
			settle(SETTLE_CYCLES);
		end

		// Long receiver hold-off while ticks keep coming.
		pace = PACE_FREE;
		program_regs(16'd6554, 4'd6, 4'b1101);
		hold_armed = 1'b1;
		queue_random(30);
		settle(SETTLE_CYCLES);

		// Sender pauses after each tick until all of its pulses are out.
		for (k = 0; k < 6; k++) begin
			tick_q.push_back(TIME_W'($urandom_range(65535, 8192)));
			settle(0);
		end

		// Final drain, bounded so a missing pulse is reported rather than hung on.
		waited = 0;
		while ((tick_q.size() != 0 || in_valid || due_pulses.size() != 0) &&
			waited < FINAL_WAIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (due_pulses.size() != 0 || tick_q.size() != 0) begin
			$display("%0t: %0d pulses never arrived, %0d ticks never accepted",
				$time, due_pulses.size(), tick_q.size());
			errors++;
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog on the whole run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> ring_chase_pulse_sequencer_top.f
design/rcps_pkg.sv
design/rcps_front.sv
design/rcps_queue.sv
design/rcps_back.sv
design/ring_chase_pulse_sequencer_top.sv
verif/tb_ring_chase_pulse_sequencer_top.sv
